// ===== rtl/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// shared constants and controller/datapath command and status types for the
// binary to decimal ascii converter
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

    localparam int BIN_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CHAR_W     = 6;
    localparam int CNT_W      = $clog2(BIN_W);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    localparam logic [CNT_W-1:0]   LAST_SHIFT = CNT_W'(BIN_W - 1);
    localparam logic [IDX_W-1:0]   FIRST_IDX  = IDX_W'(NUM_DIGITS - 1);
    localparam logic [IDX_W-1:0]   LAST_IDX   = '0;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  ASCII_NINE = CHAR_W'(57);
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] ADJ_ADD    = DIGIT_W'(3);

    typedef struct packed {
        logic load;
        logic shift;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic conv_done;
        logic emit_done;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/b2da_ctrl.sv =====
// ----------------------------------------------------------------------------
// b2da_ctrl
// sequencer: load, 32 shift-add-3 steps, then one step per decimal digit
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    input  b2da_pkg::t_dp_sts i_sts,
    output b2da_pkg::t_dp_cmd o_cmd,
    output logic              busy
);
    import b2da_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.shift = 1'b0;
        o_cmd.emit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    a_busy_ends_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(r_state) == S_EMIT)
        else $error("busy dropped outside digit output");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !busy && !o_cmd.shift && !o_cmd.emit)
        else $error("load issued while busy");

    a_conv_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV && i_sts.conv_done) |=> r_state == S_EMIT)
        else $error("conversion end not followed by output");

endmodule

`default_nettype wire

// ===== rtl/b2da_dpath.sv =====
// ----------------------------------------------------------------------------
// b2da_dpath
// shift-add-3 binary to bcd register, then digit output with leading zero
// suppression into a registered result word
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_dpath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  b2da_pkg::t_dp_cmd                   i_cmd,
    input  wire  [b2da_pkg::BIN_W-1:0]          i_value,
    output b2da_pkg::t_dp_sts                   o_sts,
    output logic                                o_strobe,
    output logic [b2da_pkg::CHAR_W-1:0]         o_digit_char,
    output logic                                o_last_digit
);
    import b2da_pkg::*;

    logic [BIN_W-1:0]   r_bin;
    logic [BIN_W-1:0]   n_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   n_bcd;
    logic [BCD_W-1:0]   adj_bcd;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic               r_seen;
    logic               n_seen;
    logic               r_strobe;
    logic               n_strobe;
    logic [CHAR_W-1:0]  r_char;
    logic [CHAR_W-1:0]  n_char;
    logic               r_last;
    logic               n_last;
    logic [DIGIT_W-1:0] top_digit;
    logic               is_last;
    logic               show;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= ADJ_LIMIT) begin
                adj_bcd[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W] + ADJ_ADD;
            end else begin
                adj_bcd[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: DIGIT_W];
    assign is_last   = (r_idx == LAST_IDX);
    assign show      = (top_digit != '0) || r_seen || is_last;

    always_comb begin
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_seen   = r_seen;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        if (i_cmd.load) begin
            n_bin  = i_value;
            n_bcd  = '0;
            n_cnt  = '0;
            n_idx  = FIRST_IDX;
            n_seen = 1'b0;
        end else if (i_cmd.shift) begin
            n_bin = {r_bin[BIN_W-2:0], 1'b0};
            n_bcd = {adj_bcd[BCD_W-2:0], r_bin[BIN_W-1]};
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_cmd.emit) begin
            n_bcd    = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            n_idx    = r_idx - IDX_W'(1);
            n_seen   = show;
            n_strobe = show;
            n_char   = ASCII_ZERO + CHAR_W'(top_digit);
            n_last   = is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_idx  <= n_idx;
        r_seen <= n_seen;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_sts.conv_done = (r_cnt == LAST_SHIFT);
    assign o_sts.emit_done = is_last;
    assign o_strobe        = r_strobe;
    assign o_digit_char    = r_char;
    assign o_last_digit    = r_last;

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_digit_char >= ASCII_ZERO && o_digit_char <= ASCII_NINE))
        else $error("digit word out of range");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_digit) |=> !o_strobe)
        else $error("word straight after last digit");

    a_emit_digit_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> top_digit <= DIGIT_W'(9))
        else $error("bcd digit above nine");

endmodule

`default_nettype wire

// ===== rtl/binary_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// unsigned 32-bit value to decimal ascii digits, most significant first,
// leading zeros suppressed, last digit flagged
//
// channel   direction  handshake            word
// input     in         start & !busy        i_value
// result    out        o_strobe (1 cycle)   o_digit_char, o_last_digit
//
// an accepted value keeps busy high through 32 shift-add-3 steps in the
// bcd register, then one step per digit position over all 10 positions;
// each digit word appears the cycle after its position is scanned, so the
// run of 1 to 10 words ends in the same cycle that busy falls
// a new value may be started in the cycle busy is low; the receiver cannot
// stall, words are never held
// reset is synchronous, active low, and returns the sequencer to idle
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [b2da_pkg::BIN_W-1:0]   i_value,
    output logic                         o_strobe,
    output logic [b2da_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                         o_last_digit
);
    import b2da_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    b2da_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    b2da_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_value),
        .o_sts        (sts),
        .o_strobe     (o_strobe),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule

`default_nettype wire
